>>> rtl/mi3_pkg.sv
package mi3_pkg;

    // entry, cofactor and determinant widths (all exact, no rounding before the divide)
    localparam int EW     = 32;
    localparam int CW     = 65;
    localparam int DW     = 98;
    localparam int QDEPTH = 2;
    localparam int QPW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);
    // quotient bits kept per lane: 32 result bits plus two overflow bits
    localparam int QB     = 34;

    typedef logic signed [EW-1:0] mi3_ent_t;

    typedef struct packed {
        mi3_ent_t a_r0c0;
        mi3_ent_t a_r0c1;
        mi3_ent_t a_r0c2;
        mi3_ent_t a_r1c0;
        mi3_ent_t a_r1c1;
        mi3_ent_t a_r1c2;
        mi3_ent_t a_r2c0;
        mi3_ent_t a_r2c1;
        mi3_ent_t a_r2c2;
    } mi3_in_t;

    typedef struct packed {
        mi3_ent_t inv_r0c0;
        mi3_ent_t inv_r0c1;
        mi3_ent_t inv_r0c2;
        mi3_ent_t inv_r1c0;
        mi3_ent_t inv_r1c1;
        mi3_ent_t inv_r1c2;
        mi3_ent_t inv_r2c0;
        mi3_ent_t inv_r2c1;
        mi3_ent_t inv_r2c2;
        logic     singular;
        logic     saturated;
    } mi3_out_t;

    // one job between front and back: signed cofactors (index row*3+col) and determinant
    typedef struct packed {
        logic [8:0][CW-1:0] cof;
        logic [DW-1:0]      det;
    } mi3_job_t;

    typedef struct packed {
        logic full;
        logic nonempty;
    } mi3_qstat_t;

endpackage

>>> rtl/mi3_front.sv
module mi3_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               mat_valid,
    output logic               mat_stall,
    input  mi3_pkg::mi3_in_t   mat,
    input  mi3_pkg::mi3_qstat_t qstat,
    output logic               push,
    output mi3_pkg::mi3_job_t  job
);

    logic signed [mi3_pkg::EW-1:0]   a_w [9];
    logic                            en;
    logic [3:0]                      v_reg;

    logic signed [2*mi3_pkg::EW-1:0] p0_reg [9];
    logic signed [2*mi3_pkg::EW-1:0] p1_reg [9];
    logic signed [mi3_pkg::EW-1:0]   r0a_reg [3];
    logic signed [mi3_pkg::EW-1:0]   r0b_reg [3];
    logic signed [mi3_pkg::EW-1:0]   r0c_reg [3];
    logic signed [mi3_pkg::CW-1:0]   cofa_reg [9];
    logic signed [mi3_pkg::CW-1:0]   cofb_reg [9];
    logic signed [mi3_pkg::CW-1:0]   cofc_reg [9];
    logic signed [mi3_pkg::CW:0]     pl_reg [3];
    logic signed [mi3_pkg::CW:0]     ph_reg [3];
    logic signed [mi3_pkg::DW-1:0]   det_reg;
    logic signed [mi3_pkg::DW-1:0]   det_next;

    assign a_w[0] = mat.a_r0c0;
    assign a_w[1] = mat.a_r0c1;
    assign a_w[2] = mat.a_r0c2;
    assign a_w[3] = mat.a_r1c0;
    assign a_w[4] = mat.a_r1c1;
    assign a_w[5] = mat.a_r1c2;
    assign a_w[6] = mat.a_r2c0;
    assign a_w[7] = mat.a_r2c1;
    assign a_w[8] = mat.a_r2c2;

    // hold the whole front while the queue is full
    assign en        = !qstat.full;
    assign mat_stall = qstat.full;
    assign push      = en && v_reg[3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[2:0], mat_valid};
        end
    end

    genvar k;
    generate
        for (k = 0; k < 9; k++)
        begin : g_cof
            localparam int I  = k / 3;
            localparam int J  = k % 3;
            localparam int R0 = (I == 0) ? 1 : 0;
            localparam int R1 = (I == 2) ? 1 : 2;
            localparam int C0 = (J == 0) ? 1 : 0;
            localparam int C1 = (J == 2) ? 1 : 2;
            logic signed [mi3_pkg::CW-1:0] diff;

            assign diff = mi3_pkg::CW'(p0_reg[k]) - mi3_pkg::CW'(p1_reg[k]);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    p0_reg[k]   <= a_w[R0*3+C0] * a_w[R1*3+C1];
                    p1_reg[k]   <= a_w[R0*3+C1] * a_w[R1*3+C0];
                    cofa_reg[k] <= ((I + J) % 2 == 1) ? -diff : diff;
                    cofb_reg[k] <= cofa_reg[k];
                    cofc_reg[k] <= cofb_reg[k];
                end
            end
        end

        for (k = 0; k < 3; k++)
        begin : g_det
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r0a_reg[k] <= a_w[k];
                    r0b_reg[k] <= r0a_reg[k];
                    pl_reg[k]  <= r0b_reg[k] * $signed({1'b0, cofa_reg[k][31:0]});
                    ph_reg[k]  <= r0b_reg[k] * $signed(cofa_reg[k][mi3_pkg::CW-1:32]);
                    r0c_reg[k] <= r0b_reg[k];
                end
            end
        end
    endgenerate

    always_comb
    begin
        det_next = '0;
        for (int j = 0; j < 3; j++)
        begin
            det_next = det_next + (mi3_pkg::DW'(ph_reg[j]) <<< 32) + mi3_pkg::DW'(pl_reg[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det_reg <= det_next;
        end
    end

    always_comb
    begin
        for (int n = 0; n < 9; n++)
        begin
            job.cof[n] = cofc_reg[n];
        end
        job.det = det_reg;
    end

endmodule

>>> rtl/mi3_queue.sv
module mi3_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  mi3_pkg::mi3_job_t   wr_job,
    input  logic                pop,
    output mi3_pkg::mi3_job_t   rd_job,
    output mi3_pkg::mi3_qstat_t qstat
);

    mi3_pkg::mi3_job_t           mem [mi3_pkg::QDEPTH];
    logic [mi3_pkg::QPW-1:0]     wr_ptr_reg;
    logic [mi3_pkg::QPW-1:0]     rd_ptr_reg;
    logic [mi3_pkg::QCW-1:0]     count_reg;
    logic [mi3_pkg::QCW-1:0]     count_next;

    assign qstat.full     = (count_reg == mi3_pkg::QCW'(mi3_pkg::QDEPTH));
    assign qstat.nonempty = (count_reg != '0);
    assign rd_job         = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

>>> rtl/mi3_back.sv
module mi3_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mi3_pkg::mi3_qstat_t qstat,
    input  mi3_pkg::mi3_job_t   job,
    output logic                pop,
    output logic                inv_valid,
    input  logic                inv_stall,
    output mi3_pkg::mi3_out_t   inv
);

    localparam int NW = mi3_pkg::CW + 2 * FRAC_BITS;
    localparam int SW = mi3_pkg::DW + mi3_pkg::QB;
    localparam int RW = (NW > SW) ? NW : SW;
    localparam int QB = mi3_pkg::QB;

    logic                       en;
    logic [QB:0]                v_reg;
    logic [RW-1:0]              rem_reg [QB+1][9];
    logic [QB-1:0]              quo_reg [QB+1][9];
    logic [mi3_pkg::DW-1:0]     dm_reg [QB+1];
    logic [8:0]                 neg_reg [QB+1];
    logic [QB:0]                sing_reg;
    logic                       inv_valid_reg;
    mi3_pkg::mi3_out_t          inv_reg;
    mi3_pkg::mi3_out_t          inv_next;
    logic signed [mi3_pkg::EW-1:0] lane_val [9];
    logic [8:0]                 lane_sat;
    logic                       det_neg;

    // advance the whole pipe whenever the output register can take a beat
    assign en        = !inv_valid_reg || !inv_stall;
    assign pop       = en && qstat.nonempty;
    assign inv_valid = inv_valid_reg;
    assign inv       = inv_reg;
    assign det_neg   = job.det[mi3_pkg::DW-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            inv_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg         <= {v_reg[QB-1:0], qstat.nonempty};
            inv_valid_reg <= v_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dm_reg[0]   <= det_neg ? (~job.det + 1'b1) : job.det;
            sing_reg[0] <= (job.det == '0);
        end
    end

    genvar s, l;
    generate
        // stage 0: magnitudes and result signs, output lane i*3+j reads cofactor j*3+i
        for (l = 0; l < 9; l++)
        begin : g_load
            localparam int SRC = (l % 3) * 3 + (l / 3);
            logic [mi3_pkg::CW-1:0] c;
            logic [mi3_pkg::CW-1:0] cmag;

            assign c    = job.cof[SRC];
            assign cmag = c[mi3_pkg::CW-1] ? (~c + 1'b1) : c;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[0][l] <= RW'(cmag) << (2 * FRAC_BITS);
                    quo_reg[0][l] <= '0;
                    neg_reg[0][l] <= c[mi3_pkg::CW-1] ^ det_neg;
                end
            end
        end

        // one quotient bit per stage, most significant first
        for (s = 0; s < QB; s++)
        begin : g_stage
            localparam int B = QB - 1 - s;
            logic [RW-1:0] dsh;

            assign dsh = RW'(dm_reg[s]) << B;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dm_reg[s+1]   <= dm_reg[s];
                    neg_reg[s+1]  <= neg_reg[s];
                    sing_reg[s+1] <= sing_reg[s];
                end
            end

            for (l = 0; l < 9; l++)
            begin : g_lane
                logic ge;

                assign ge = (rem_reg[s][l] >= dsh);

                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        rem_reg[s+1][l] <= ge ? (rem_reg[s][l] - dsh) : rem_reg[s][l];
                        quo_reg[s+1][l] <= quo_reg[s][l] | (QB'(ge) << B);
                    end
                end
            end
        end

        // clamp to the 32-bit range and apply the sign; lanes of a singular matrix read zero
        for (l = 0; l < 9; l++)
        begin : g_sat
            logic [QB-1:0]          q;
            logic                   n;
            logic                   high;
            logic [mi3_pkg::EW-1:0] lim;
            logic [mi3_pkg::EW-1:0] mag;

            assign q    = quo_reg[QB][l];
            assign n    = neg_reg[QB][l];
            assign high = q[QB-1] | q[QB-2];
            assign lim  = n ? {1'b1, {(mi3_pkg::EW-1){1'b0}}} : {1'b0, {(mi3_pkg::EW-1){1'b1}}};
            assign lane_sat[l] = high || (q[mi3_pkg::EW-1:0] > lim);
            assign mag  = lane_sat[l] ? lim : q[mi3_pkg::EW-1:0];
            assign lane_val[l] = sing_reg[QB] ? '0 : (n ? (~mag + 1'b1) : mag);
        end
    endgenerate

    always_comb
    begin
        inv_next.inv_r0c0  = lane_val[0];
        inv_next.inv_r0c1  = lane_val[1];
        inv_next.inv_r0c2  = lane_val[2];
        inv_next.inv_r1c0  = lane_val[3];
        inv_next.inv_r1c1  = lane_val[4];
        inv_next.inv_r1c2  = lane_val[5];
        inv_next.inv_r2c0  = lane_val[6];
        inv_next.inv_r2c1  = lane_val[7];
        inv_next.inv_r2c2  = lane_val[8];
        inv_next.singular  = sing_reg[QB];
        inv_next.saturated = !sing_reg[QB] && (lane_sat != '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            inv_reg <= inv_next;
        end
    end

endmodule

>>> rtl/matrix_inverse_3x3_core.sv
// channel | direction | handshake              | beat
// mat     | in        | mat_valid / mat_stall  | nine Q entries of one 3x3 matrix
// inv     | out       | inv_valid / inv_stall  | nine inverse entries, singular, saturated
//
// Throughput is one matrix per cycle while no stall is raised; the back
// has 34 quotient stages in nine parallel divider lanes.
// The front holds the cofactor and determinant pipe; a two-entry queue parts it
// from the back, whose restoring divider lanes set the latency.
// Reset clears valid bits, queue pointers and count only; payload registers are not reset.
// mat_stall rises only while the queue is full; inv_stall holds the back pipe.
module matrix_inverse_3x3_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              mat_valid,
    output logic              mat_stall,
    input  mi3_pkg::mi3_in_t  mat,
    output logic              inv_valid,
    input  logic              inv_stall,
    output mi3_pkg::mi3_out_t inv
);

    mi3_pkg::mi3_qstat_t qstat;
    mi3_pkg::mi3_job_t   wr_job;
    mi3_pkg::mi3_job_t   rd_job;
    logic                push;
    logic                pop;

    // front: exact cofactors and determinant
    mi3_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .mat_valid (mat_valid),
        .mat_stall (mat_stall),
        .mat       (mat),
        .qstat     (qstat),
        .push      (push),
        .job       (wr_job)
    );

    // decouple: hold finished jobs while the back is stalled
    mi3_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_job (wr_job),
        .pop    (pop),
        .rd_job (rd_job),
        .qstat  (qstat)
    );

    // back: divide adjugate by determinant, saturate, drive the result beat
    mi3_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .qstat     (qstat),
        .job       (rd_job),
        .pop       (pop),
        .inv_valid (inv_valid),
        .inv_stall (inv_stall),
        .inv       (inv)
    );

endmodule
